FILE: hdl/rtpi_pkg.sv
package rtpi_pkg;

    // default coordinate format, signed fixed point
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // dot products and the scaled quotient work on this width
    localparam int DOT_WIDTH  = 64;
    localparam int HALF_WIDTH = DOT_WIDTH / 2;

    // the normal is scaled so that each component fits NORM_SPAN - COORD_WIDTH + 2 bits
    localparam int NORM_SPAN = 60;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_DEGEN    = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_BEHIND   = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_index_t;

endpackage

FILE: hdl/rtpi_div.sv
module rtpi_div #(
    parameter int COORD_WIDTH = rtpi_pkg::COORD_WIDTH_DEF
) (
    input  logic                                           clk,
    input  logic [COORD_WIDTH+rtpi_pkg::DOT_WIDTH-1:0]     dividend,
    input  logic [rtpi_pkg::DOT_WIDTH-1:0]                 divisor,
    input  logic                                           ovf_in,
    output logic [COORD_WIDTH:0]                           quotient,
    output logic                                           ovf_out
);
    import rtpi_pkg::*;

    localparam int PW = COORD_WIDTH + DOT_WIDTH;
    localparam int QW = COORD_WIDTH + 1;

    logic [PW-1:0]        rem_reg [QW-1];
    logic [DOT_WIDTH-1:0] d_reg   [QW-1];
    logic [QW-1:0]        q_reg   [QW];
    logic                 o_reg   [QW];

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int SH = COORD_WIDTH - j;
        logic [PW-1:0]        rem_in;
        logic [DOT_WIDTH-1:0] d_in;
        logic [QW-1:0]        q_in;
        logic                 o_in;
        logic [PW-1:0]        dsh;
        logic                 ge;

        if (j == 0) begin : g_first
            assign rem_in = dividend;
            assign d_in   = divisor;
            assign q_in   = '0;
            assign o_in   = ovf_in;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign o_in   = o_reg[j-1];
        end

        assign dsh = PW'(d_in) << SH;
        assign ge  = rem_in >= dsh;

        // take the shifted divisor off where it fits
        always_ff @(posedge clk)
        begin
            q_reg[j] <= ge ? (q_in | (QW'(1) << SH)) : q_in;
            o_reg[j] <= o_in;
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? (rem_in - dsh) : rem_in;
                d_reg[j]   <= d_in;
            end
        end
    end

    assign quotient = q_reg[QW-1];
    assign ovf_out  = o_reg[QW-1];

endmodule

FILE: hdl/ray_triangle_plane_intersect.sv
// Ray against triangle plane, fully pipelined: one triangle may be started in
// every clock and busy stays low. Each triangle gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it, so it
// must take every result as it comes. The depth is set by the bit-per-stage
// divider that forms the scaled intersection, COORD_WIDTH + 1 stages, behind
// fifteen stages of edge, cross product, normal scaling, dot products and the
// |dir| * |num| product. The ray registers are read while items are in flight,
// so write them only when the pipeline is empty.
module ray_triangle_plane_intersect #(
    parameter int COORD_WIDTH = rtpi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic [31:0]                              primitive_id,
    input  logic signed [COORD_WIDTH-1:0]            vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0]            vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0]            vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0]            vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0]            vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0]            vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0]            vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0]            vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0]            vertex_c_z,
    input  logic                                     wr_en,
    input  logic [rtpi_pkg::CFG_INDEX_WIDTH-1:0]     wr_index,
    input  logic [COORD_WIDTH-1:0]                   wr_data,
    output logic                                     done,
    output logic [31:0]                              tag_out,
    output logic [1:0]                               status,
    output logic signed [COORD_WIDTH-1:0]            hit_x,
    output logic signed [COORD_WIDTH-1:0]            hit_y,
    output logic signed [COORD_WIDTH-1:0]            hit_z,
    output logic                                     saturated
);
    import rtpi_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int EW    = W + 1;
    localparam int PRW   = 2 * EW;
    localparam int CW    = PRW + 1;
    localparam int NB    = NORM_SPAN - W;
    localparam int NW    = NB + 2;
    localparam int SW    = $clog2(CW + 1);
    localparam int CHUNK = 8;
    localparam int CIW   = 3;
    localparam int NCH   = (CW + CHUNK - 1) / CHUNK;
    localparam int DPW   = NW + W;
    localparam int NPW   = NW + EW;
    localparam int MW    = W + HALF_WIDTH;
    localparam int PW    = W + DOT_WIDTH;
    localparam int QW    = W + 1;
    localparam int LINE  = 15 + QW;
    localparam int SLEN  = LINE - 11;

    // ray registers
    logic signed [W-1:0] origin_reg [3];
    logic signed [W-1:0] dir_reg    [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= '0;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= W'(1) << FRAC_BITS;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_ORIGIN_X: origin_reg[0] <= wr_data;
                REG_ORIGIN_Y: origin_reg[1] <= wr_data;
                REG_ORIGIN_Z: origin_reg[2] <= wr_data;
                REG_DIR_X:    dir_reg[0]    <= wr_data;
                REG_DIR_Y:    dir_reg[1]    <= wr_data;
                REG_DIR_Z:    dir_reg[2]    <= wr_data;
                default:      ;
            endcase
        end
    end

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic signed [W-1:0] va [3];
    logic signed [W-1:0] vb [3];
    logic signed [W-1:0] vc [3];
    assign va = '{vertex_a_x, vertex_a_y, vertex_a_z};
    assign vb = '{vertex_b_x, vertex_b_y, vertex_b_z};
    assign vc = '{vertex_c_x, vertex_c_y, vertex_c_z};

    // valid and tag travel down one line
    logic        v_line_reg   [LINE];
    logic [31:0] tag_line_reg [LINE];
    status_t     stat_line_reg [SLEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < LINE; i++) begin
                v_line_reg[i] <= 1'b0;
            end
        end else begin
            v_line_reg[0] <= accept;
            for (int i = 1; i < LINE; i++) begin
                v_line_reg[i] <= v_line_reg[i-1];
            end
        end
    end

    // pipeline payload
    logic signed [EW-1:0]  u1_reg [3], v1_reg [3], d1_reg [3], d2_reg [3], d3_reg [3];
    logic signed [EW-1:0]  d4_reg [3], d5_reg [3], d6_reg [3], d7_reg [3], d8_reg [3];
    logic signed [EW-1:0]  d9_reg [3];
    logic signed [PRW-1:0] p2_reg [6];
    logic signed [CW-1:0]  c3_reg [3], c4_reg [3], c5_reg [3], c6_reg [3], c7_reg [3];
    logic signed [CW-1:0]  c8_reg [3];
    logic [CW-1:0]         m4_reg [3], m5_reg [3], m6_reg [3];
    logic                  neg4_reg [3], neg5_reg [3], neg6_reg [3];
    logic                  zero4_reg, zero5_reg, zero6_reg, zero7_reg, zero8_reg;
    logic                  zero9_reg, zero10_reg, zero11_reg;
    logic [NCH-1:0]        nz5_next [3], nz5_reg [3];
    logic [CIW-1:0]        lead5_next [3][NCH], lead5_reg [3][NCH];
    logic [SW-1:0]         l6_next [3], l6_reg [3];
    logic [SW-1:0]         base7 [3], sh7 [3], s7_next [3], s7_reg [3];
    logic                  adj7 [3];
    logic [SW-1:0]         s8_next, s8_reg;
    logic signed [NW-1:0]  n9_reg [3];
    logic signed [DPW-1:0] dp10_reg [3];
    logic signed [NPW-1:0] np10_reg [3];
    logic signed [DOT_WIDTH-1:0] den11_reg, num11_reg;
    status_t               stat12_next;
    logic [DOT_WIDTH-1:0]  an12_reg, ad12_reg, ad13_reg, ad14_reg, ad15_reg;
    logic [W-1:0]          adir [3];
    logic [MW-1:0]         lo13_reg [3], hi13_reg [3];
    logic [PW-1:0]         p14_reg [3], p15_reg [3], t14_reg;
    logic                  ovf15_reg [3];

    // leading-one search inside each byte of the magnitude
    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            for (int h = 0; h < NCH; h++) begin
                nz5_next[k][h]   = 1'b0;
                lead5_next[k][h] = '0;
                for (int b = 0; b < CHUNK; b++) begin
                    if (h * CHUNK + b < CW) begin
                        if (m4_reg[k][h * CHUNK + b]) begin
                            nz5_next[k][h]   = 1'b1;
                            lead5_next[k][h] = CIW'(b);
                        end
                    end
                end
            end
        end
    end

    // bit length from the highest non-zero byte
    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            l6_next[k] = '0;
            for (int h = 0; h < NCH; h++) begin
                if (nz5_reg[k][h]) begin
                    l6_next[k] = SW'(h * CHUNK) + SW'(lead5_reg[k][h]) + SW'(1);
                end
            end
        end
    end

    // smallest shift per component; a positive power of two sits on the limit
    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            base7[k] = (l6_reg[k] > SW'(NB)) ? (l6_reg[k] - SW'(NB)) : '0;
            sh7[k]   = l6_reg[k] - SW'(NB) - SW'(1);
            adj7[k]  = !neg6_reg[k] && (l6_reg[k] > SW'(NB))
                       && ((m6_reg[k] >> sh7[k]) == (CW'(1) << NB));
            s7_next[k] = base7[k] - SW'(adj7[k]);
        end
    end

    always_comb
    begin
        s8_next = s7_reg[0];
        if (s7_reg[1] > s8_next) begin
            s8_next = s7_reg[1];
        end
        if (s7_reg[2] > s8_next) begin
            s8_next = s7_reg[2];
        end
    end

    // classify the item
    always_comb
    begin
        priority if (zero11_reg) begin
            stat12_next = ST_DEGEN;
        end else if (den11_reg == '0) begin
            stat12_next = ST_PARALLEL;
        end else if ((num11_reg != '0) && (num11_reg[DOT_WIDTH-1] != den11_reg[DOT_WIDTH-1])) begin
            stat12_next = ST_BEHIND;
        end else begin
            stat12_next = ST_HIT;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            adir[k] = dir_reg[k][W-1] ? (W'(0) - W'(dir_reg[k])) : W'(dir_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        tag_line_reg[0] <= primitive_id;
        for (int i = 1; i < LINE; i++) begin
            tag_line_reg[i] <= tag_line_reg[i-1];
        end
        stat_line_reg[0] <= stat12_next;
        for (int i = 1; i < SLEN; i++) begin
            stat_line_reg[i] <= stat_line_reg[i-1];
        end

        // edges and vertex offset from the origin
        for (int k = 0; k < 3; k++) begin
            u1_reg[k] <= {vb[k][W-1], vb[k]} - {va[k][W-1], va[k]};
            v1_reg[k] <= {vc[k][W-1], vc[k]} - {va[k][W-1], va[k]};
            d1_reg[k] <= {va[k][W-1], va[k]} - {origin_reg[k][W-1], origin_reg[k]};
        end

        // cross product terms
        p2_reg[0] <= PRW'(u1_reg[1]) * PRW'(v1_reg[2]);
        p2_reg[1] <= PRW'(u1_reg[2]) * PRW'(v1_reg[1]);
        p2_reg[2] <= PRW'(u1_reg[2]) * PRW'(v1_reg[0]);
        p2_reg[3] <= PRW'(u1_reg[0]) * PRW'(v1_reg[2]);
        p2_reg[4] <= PRW'(u1_reg[0]) * PRW'(v1_reg[1]);
        p2_reg[5] <= PRW'(u1_reg[1]) * PRW'(v1_reg[0]);

        for (int k = 0; k < 3; k++) begin
            c3_reg[k] <= CW'(p2_reg[2*k]) - CW'(p2_reg[2*k+1]);

            c4_reg[k]   <= c3_reg[k];
            neg4_reg[k] <= c3_reg[k][CW-1];
            m4_reg[k]   <= c3_reg[k][CW-1] ? ~c3_reg[k] : c3_reg[k];

            c5_reg[k]   <= c4_reg[k];
            m5_reg[k]   <= m4_reg[k];
            neg5_reg[k] <= neg4_reg[k];
            nz5_reg[k]  <= nz5_next[k];
            for (int h = 0; h < NCH; h++) begin
                lead5_reg[k][h] <= lead5_next[k][h];
            end

            c6_reg[k]   <= c5_reg[k];
            m6_reg[k]   <= m5_reg[k];
            neg6_reg[k] <= neg5_reg[k];
            l6_reg[k]   <= l6_next[k];

            c7_reg[k] <= c6_reg[k];
            s7_reg[k] <= s7_next[k];

            c8_reg[k] <= c7_reg[k];

            // scaled normal
            n9_reg[k] <= NW'(c8_reg[k] >>> s8_reg);

            dp10_reg[k] <= DPW'(n9_reg[k]) * DPW'(dir_reg[k]);
            np10_reg[k] <= NPW'(n9_reg[k]) * NPW'(d9_reg[k]);

            d2_reg[k] <= d1_reg[k];
            d3_reg[k] <= d2_reg[k];
            d4_reg[k] <= d3_reg[k];
            d5_reg[k] <= d4_reg[k];
            d6_reg[k] <= d5_reg[k];
            d7_reg[k] <= d6_reg[k];
            d8_reg[k] <= d7_reg[k];
            d9_reg[k] <= d8_reg[k];

            // |dir| * |num| in two halves, then joined
            lo13_reg[k] <= MW'(adir[k]) * MW'(an12_reg[HALF_WIDTH-1:0]);
            hi13_reg[k] <= MW'(adir[k]) * MW'(an12_reg[DOT_WIDTH-1:HALF_WIDTH]);
            p14_reg[k]  <= PW'(lo13_reg[k]) + (PW'(hi13_reg[k]) << HALF_WIDTH);
            p15_reg[k]  <= p14_reg[k];
            ovf15_reg[k] <= p14_reg[k] >= t14_reg;
        end

        zero4_reg  <= (c3_reg[0] == '0) && (c3_reg[1] == '0) && (c3_reg[2] == '0);
        zero5_reg  <= zero4_reg;
        zero6_reg  <= zero5_reg;
        zero7_reg  <= zero6_reg;
        zero8_reg  <= zero7_reg;
        zero9_reg  <= zero8_reg;
        zero10_reg <= zero9_reg;
        zero11_reg <= zero10_reg;
        s8_reg     <= s8_next;

        den11_reg <= DOT_WIDTH'(dp10_reg[0]) + DOT_WIDTH'(dp10_reg[1]) + DOT_WIDTH'(dp10_reg[2]);
        num11_reg <= DOT_WIDTH'(np10_reg[0]) + DOT_WIDTH'(np10_reg[1]) + DOT_WIDTH'(np10_reg[2]);

        an12_reg <= num11_reg[DOT_WIDTH-1] ? (DOT_WIDTH'(0) - num11_reg) : num11_reg;
        ad12_reg <= den11_reg[DOT_WIDTH-1] ? (DOT_WIDTH'(0) - den11_reg) : den11_reg;
        ad13_reg <= ad12_reg;
        ad14_reg <= ad13_reg;
        ad15_reg <= ad14_reg;

        // quotient above 2^W once the product reaches (2^W + 1) * |den|
        t14_reg <= (PW'(ad13_reg) << W) + PW'(ad13_reg);
    end

    // truncating divide per coordinate
    logic [QW-1:0] q_div [3];
    logic          ovf_div [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        rtpi_div #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_div (
            .clk      (clk),
            .dividend (p15_reg[k]),
            .divisor  (ad15_reg),
            .ovf_in   (ovf15_reg[k]),
            .quotient (q_div[k]),
            .ovf_out  (ovf_div[k])
        );
    end

    // add to the origin and clamp
    logic signed [W+1:0] sum_f [3];
    logic [W-1:0]        hit_next [3];
    logic                clip_f [3];
    logic                sat_next;
    status_t             stat_last;

    assign stat_last = stat_line_reg[SLEN-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            sum_f[k] = dir_reg[k][W-1]
                ? ({{2{origin_reg[k][W-1]}}, origin_reg[k]} - {1'b0, q_div[k]})
                : ({{2{origin_reg[k][W-1]}}, origin_reg[k]} + {1'b0, q_div[k]});
            if (ovf_div[k]) begin
                clip_f[k]   = 1'b1;
                hit_next[k] = dir_reg[k][W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else if ((sum_f[k][W+1:W-1] != 3'b000) && (sum_f[k][W+1:W-1] != 3'b111)) begin
                clip_f[k]   = 1'b1;
                hit_next[k] = sum_f[k][W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                clip_f[k]   = 1'b0;
                hit_next[k] = sum_f[k][W-1:0];
            end
            if (stat_last != ST_HIT) begin
                hit_next[k] = '0;
            end
        end
        sat_next = (stat_last == ST_HIT) && (clip_f[0] || clip_f[1] || clip_f[2]);
    end

    // result register
    logic                done_reg;
    logic [31:0]         tag_reg;
    status_t             status_reg;
    logic [W-1:0]        hit_reg [3];
    logic                sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= v_line_reg[LINE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg    <= tag_line_reg[LINE-1];
        status_reg <= stat_last;
        sat_reg    <= sat_next;
        for (int k = 0; k < 3; k++) begin
            hit_reg[k] <= hit_next[k];
        end
    end

    assign done      = done_reg;
    assign tag_out   = tag_reg;
    assign status    = status_reg;
    assign hit_x     = hit_reg[0];
    assign hit_y     = hit_reg[1];
    assign hit_z     = hit_reg[2];
    assign saturated = sat_reg;

endmodule
